### design/esc_pkg.sv
// Shared types, codes, constants and helpers for the sensor compensation block.
`default_nettype none
package esc_pkg;
    localparam int DW = 64;
    localparam int HW = 32;

    typedef enum logic [1:0] {
        CMD_TEMP  = 2'd0,
        CMD_PRESS = 2'd1,
        CMD_HUM   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_TEMP    = 3'd0,
        REG_PRESS_A = 3'd1,
        REG_PRESS_B = 3'd2,
        REG_PRESS_C = 3'd3,
        REG_HUM_A   = 3'd4,
        REG_HUM_B   = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_DIVGO,
        S_DIVWAIT,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        ST_T0, ST_T1, ST_T2, ST_T3,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9,
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7
    } step_t;

    localparam logic [63:0] K_128000   = 64'd128000;
    localparam logic [63:0] K_1048576  = 64'd1048576;
    localparam logic [63:0] K_3125     = 64'd3125;
    localparam logic [31:0] K_76800    = 32'd76800;
    localparam logic [31:0] K_HUM_MAX  = 32'd419430400;
    localparam logic [31:0] K_16384    = 32'd16384;
    localparam logic [31:0] K_2097152  = 32'd2097152;
    localparam logic [31:0] K_32768    = 32'd32768;
    localparam logic [31:0] K_8192     = 32'd8192;
    localparam logic [63:0] K_BIT47    = 64'h0000_8000_0000_0000;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx8(input logic [7:0] v);
        return {{56{v[7]}}, v};
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [5:0] n);
        return $unsigned($signed(v) >>> n);
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] v, input logic [5:0] n);
        return $unsigned($signed(v) >>> n);
    endfunction
endpackage
`default_nettype wire

### design/env_sensor_compensation_top.sv
// Top level: sequencer for integer temperature, pressure and humidity compensation.
`default_nettype none
// One item at a time. The sequencer runs each formula through one shared
// 64-bit multiplier, and pressure also goes through the bit-serial signed
// divider. in_ready is high only while the sequencer is idle; a finished
// result waits in the output register while the next item is accepted.
// Coefficient writes are taken at any time, one per cycle.
module env_sensor_compensation_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [19:0] raw_sample,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       reading_kind,
    output logic signed [32:0] reading_value,
    output logic             divisor_zero,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import esc_pkg::*;

    logic [47:0] temp_reg;
    logic [63:0] pa_reg, pb_reg;
    logic [15:0] pc_reg;
    logic [31:0] ha_reg;
    logic [39:0] hb_reg;

    state_t      state_reg, state_next;
    step_t       step_reg, step_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [19:0] adc_reg, adc_next;
    logic [31:0] fine_reg, fine_next;
    logic [63:0] r0_reg, r0_next, r1_reg, r1_next, r2_reg, r2_next;
    logic [32:0] val_reg, val_next;
    logic        zero_reg, zero_next;
    logic        ovalid_reg, ovalid_next;
    logic [1:0]  okind_reg, okind_next;
    logic [32:0] oval_reg, oval_next;
    logic        ozero_reg, ozero_next;

    logic        mul_start, mul_done, div_start, div_done;
    logic [63:0] mul_a, mul_b, mul_prod, div_quo;

    logic [31:0] t1, ta, tb, hx, lo, hsum, hres, tres;
    logic [63:0] pv1;

    esc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    esc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (r2_reg),
        .den   (r0_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign t1   = {16'd0, temp_reg[15:0]};
    assign ta   = {15'd0, adc_reg[19:3]} - {t1[30:0], 1'b0};
    assign tb   = {16'd0, adc_reg[19:4]} - t1;
    assign hx   = fine_reg - K_76800;
    assign pv1  = sx32(fine_reg) - K_128000;
    assign lo   = mul_prod[31:0];
    assign tres = asr32(lo + 32'd128, 6'd8);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            ST_T0: begin mul_a = sx32(ta);        mul_b = sx16(temp_reg[31:16]); end
            ST_T1: begin mul_a = sx32(tb);        mul_b = sx32(tb); end
            ST_T2: begin mul_a = r1_reg;          mul_b = sx16(temp_reg[47:32]); end
            ST_T3: begin mul_a = sx32(fine_reg);  mul_b = 64'd5; end
            ST_P0: begin mul_a = pv1;             mul_b = pv1; end
            ST_P1: begin mul_a = r0_reg;          mul_b = sx16(pb_reg[31:16]); end
            ST_P2: begin mul_a = pv1;             mul_b = sx16(pb_reg[15:0]); end
            ST_P3: begin mul_a = r0_reg;          mul_b = sx16(pa_reg[47:32]); end
            ST_P4: begin mul_a = pv1;             mul_b = sx16(pa_reg[31:16]); end
            ST_P5: begin mul_a = r0_reg;          mul_b = {48'd0, pa_reg[15:0]}; end
            ST_P6: begin mul_a = r2_reg;          mul_b = K_3125; end
            ST_P7: begin mul_a = asr64(r2_reg, 6'd13); mul_b = sx16(pc_reg); end
            ST_P8: begin mul_a = r0_reg;          mul_b = asr64(r2_reg, 6'd13); end
            ST_P9: begin mul_a = r2_reg;          mul_b = sx16(pb_reg[63:48]); end
            ST_H0: begin mul_a = sx32(hx);        mul_b = sx16(hb_reg[31:16]); end
            ST_H1: begin mul_a = sx32(hx);        mul_b = sx8(hb_reg[39:32]); end
            ST_H2: begin mul_a = sx32(hx);        mul_b = {56'd0, ha_reg[31:24]}; end
            ST_H3: begin mul_a = r1_reg;          mul_b = r2_reg; end
            ST_H4: begin mul_a = r1_reg;          mul_b = sx16(ha_reg[23:8]); end
            ST_H5: begin mul_a = r0_reg;          mul_b = r1_reg; end
            ST_H6: begin mul_a = r1_reg;          mul_b = r1_reg; end
            ST_H7: begin mul_a = r1_reg;          mul_b = {56'd0, ha_reg[7:0]}; end
            default: begin end
        endcase
    end

    always_comb
    begin
        hsum = {adc_reg[17:0], 14'd0} - {hb_reg[11:0], 20'd0} - lo + K_16384;
        hres = r0_reg[31:0] - asr32(lo, 6'd4);
        if (hres[31])
        begin
            hres = '0;
        end
        if (hres > K_HUM_MAX)
        begin
            hres = K_HUM_MAX;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        cmd_next    = cmd_reg;
        adc_next    = adc_reg;
        fine_next   = fine_reg;
        r0_next     = r0_reg;
        r1_next     = r1_reg;
        r2_next     = r2_reg;
        val_next    = val_reg;
        zero_next   = zero_reg;
        ovalid_next = ovalid_reg;
        okind_next  = okind_reg;
        oval_next   = oval_reg;
        ozero_next  = ozero_reg;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        in_ready    = (state_reg == S_IDLE);

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next  = command;
                    adc_next  = raw_sample;
                    val_next  = '0;
                    zero_next = 1'b0;
                    state_next = S_ISSUE;
                    case (command)
                        CMD_TEMP:  step_next = ST_T0;
                        CMD_PRESS: step_next = ST_P0;
                        CMD_HUM:   step_next = ST_H0;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_ISSUE:
            begin
                mul_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = S_ISSUE;
                    step_next  = step_t'(step_reg + 5'd1);
                    case (step_reg)
                        ST_T0: r0_next = sx32(asr32(lo, 6'd11));
                        ST_T1: r1_next = sx32(asr32(lo, 6'd12));
                        ST_T2: fine_next = r0_reg[31:0] + asr32(lo, 6'd14);
                        ST_T3:
                        begin
                            val_next   = {tres[31], tres};
                            state_next = S_DONE;
                        end
                        ST_P0: r0_next = mul_prod;
                        ST_P1: r1_next = mul_prod;
                        ST_P2: r1_next = r1_reg + (mul_prod << 17) + (sx16(pa_reg[63:48]) << 35);
                        ST_P3: r0_next = asr64(mul_prod, 6'd8);
                        ST_P4: r0_next = r0_reg + (mul_prod << 12) + K_BIT47;
                        ST_P5:
                        begin
                            r0_next = asr64(mul_prod, 6'd33);
                            r2_next = ((K_1048576 - {44'd0, adc_reg}) << 31) - r1_reg;
                            if (asr64(mul_prod, 6'd33) == 64'd0)
                            begin
                                zero_next  = 1'b1;
                                val_next   = '0;
                                state_next = S_DONE;
                            end
                        end
                        ST_P6:
                        begin
                            r2_next    = mul_prod;
                            state_next = S_DIVGO;
                        end
                        ST_P7: r0_next = mul_prod;
                        ST_P8: r0_next = asr64(mul_prod, 6'd25);
                        ST_P9:
                        begin
                            r1_next = asr64(r2_reg + r0_reg + asr64(mul_prod, 6'd19), 6'd8)
                                      + (sx16(pb_reg[47:32]) << 4);
                            val_next = {1'b0, r1_next[31:0]};
                            state_next = S_DONE;
                        end
                        ST_H0: r0_next = sx32(asr32(hsum, 6'd15));
                        ST_H1: r1_next = sx32(asr32(lo, 6'd10));
                        ST_H2: r2_next = sx32(asr32(lo, 6'd11) + K_32768);
                        ST_H3: r1_next = sx32(asr32(lo, 6'd10) + K_2097152);
                        ST_H4: r1_next = sx32(asr32(lo + K_8192, 6'd14));
                        ST_H5:
                        begin
                            r0_next = sx32(lo);
                            r1_next = sx32(asr32(lo, 6'd15));
                        end
                        ST_H6: r1_next = sx32(asr32(lo, 6'd7));
                        ST_H7:
                        begin
                            val_next   = {13'd0, hres[31:12]};
                            state_next = S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = S_DIVWAIT;
            end
            S_DIVWAIT:
            begin
                if (div_done)
                begin
                    r2_next    = div_quo;
                    step_next  = ST_P7;
                    state_next = S_ISSUE;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = cmd_reg;
                    oval_next   = val_reg;
                    ozero_next  = zero_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= ST_T0;
            ovalid_reg <= 1'b0;
            fine_reg   <= '0;
            temp_reg   <= '0;
            pa_reg     <= '0;
            pb_reg     <= '0;
            pc_reg     <= '0;
            ha_reg     <= '0;
            hb_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
            fine_reg   <= fine_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_TEMP:    temp_reg <= cfg_data[47:0];
                    REG_PRESS_A: pa_reg   <= cfg_data;
                    REG_PRESS_B: pb_reg   <= cfg_data;
                    REG_PRESS_C: pc_reg   <= cfg_data[15:0];
                    REG_HUM_A:   ha_reg   <= cfg_data[31:0];
                    REG_HUM_B:   hb_reg   <= cfg_data[39:0];
                    default:     begin end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        adc_reg   <= adc_next;
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        r2_reg    <= r2_next;
        val_reg   <= val_next;
        zero_reg  <= zero_next;
        okind_reg <= okind_next;
        oval_reg  <= oval_next;
        ozero_reg <= ozero_next;
    end

    assign cfg_ready     = 1'b1;
    assign out_valid     = ovalid_reg;
    assign reading_kind  = okind_reg;
    assign reading_value = $signed(oval_reg);
    assign divisor_zero  = ozero_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divisor_zero |-> reading_kind == CMD_PRESS && reading_value == 33'sd0)
        else $error("divisor flag on a non-pressure item");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reading_kind == CMD_HUM |->
            reading_value >= 33'sd0 && reading_value <= 33'sd102400)
        else $error("humidity out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE && !mul_done && !div_done)
        else $error("ready while arithmetic is busy");
endmodule
`default_nettype wire

### design/esc_mul.sv
// Shared 64x64 multiplier, low 64 bits, one 32x32 partial product per cycle.
`default_nettype none
module esc_mul (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [esc_pkg::DW-1:0] a,
    input  wire logic [esc_pkg::DW-1:0] b,
    output logic                      done,
    output logic [esc_pkg::DW-1:0]    prod
);
    import esc_pkg::*;

    logic [DW-1:0] a_reg, b_reg, acc_reg, acc_next;
    logic [1:0]    phase_reg, phase_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [HW-1:0] op_x, op_y;
    logic [DW-1:0] pp;

    always_comb
    begin
        op_x = a_reg[HW-1:0];
        op_y = b_reg[HW-1:0];
        case (phase_reg)
            2'd1:
            begin
                op_y = b_reg[DW-1:HW];
            end
            2'd2:
            begin
                op_x = a_reg[DW-1:HW];
            end
            default:
            begin
            end
        endcase
        pp = 64'(op_x) * 64'(op_y);
    end

    always_comb
    begin
        acc_next   = acc_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (busy_reg)
        begin
            case (phase_reg)
                2'd0:
                begin
                    acc_next   = pp;
                    phase_next = 2'd1;
                end
                2'd1:
                begin
                    acc_next   = acc_reg + {pp[HW-1:0], {HW{1'b0}}};
                    phase_next = 2'd2;
                end
                default:
                begin
                    acc_next   = acc_reg + {pp[HW-1:0], {HW{1'b0}}};
                    phase_next = 2'd0;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                end
            endcase
        end
        else if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 2'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start && !busy_reg)
        begin
            a_reg <= a;
            b_reg <= b;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule
`default_nettype wire

### design/esc_div.sv
// Signed 64-bit divider, truncating, restoring, one quotient bit per cycle.
`default_nettype none
module esc_div (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [esc_pkg::DW-1:0] num,
    input  wire logic [esc_pkg::DW-1:0] den,
    output logic                        done,
    output logic [esc_pkg::DW-1:0]      quo
);
    import esc_pkg::*;

    logic [DW-1:0] rem_reg, rem_next, q_reg, q_next, d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [DW:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[DW-1]} - {1'b0, d_reg};
        if (busy_reg)
        begin
            if (!trial[DW])
            begin
                rem_next = trial[DW-1:0];
                q_next   = {q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DW-2:0], q_reg[DW-1]};
                q_next   = {q_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rem_next  = '0;
            q_next    = num[DW-1] ? (~num + 64'd1) : num;
            d_next    = den[DW-1] ? (~den + 64'd1) : den;
            neg_next  = num[DW-1] ^ den[DW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? (~q_reg + 64'd1) : q_reg;
endmodule
`default_nettype wire
